/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the RC4 core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skip while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// RC4 package
// Widths, codes and helpers shared by the RC4 core files.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 256;
  localparam int MAX_KEY_BYTES = 16;
  localparam int KEY_LEN_W     = 5;
  localparam int KEY_POS_W     = $clog2(MAX_KEY_BYTES);
  localparam int KEY_REG_W     = 64;
  localparam int CFG_IDX_W     = 2;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [KEY_LEN_W-1:0] key_len_t;
  typedef logic [KEY_POS_W-1:0] key_pos_t;
  typedef logic [KEY_REG_W-1:0] key_reg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic {
    OP_REKEY = 1'b0,
    OP_DATA  = 1'b1
  } op_e;

  // Configuration register indexes
  localparam cfg_idx_t REG_KEY_LENGTH = 2'd0;
  localparam cfg_idx_t REG_KEY_LOW    = 2'd1;
  localparam cfg_idx_t REG_KEY_HIGH   = 2'd2;

  // Clamp the programmed key length into 1..MAX_KEY_BYTES.
  function automatic key_len_t eff_key_len(key_len_t raw);
    key_len_t n;
    n = raw;
    if (n == '0) begin
      n = key_len_t'(1);
    end
    if (n > key_len_t'(MAX_KEY_BYTES)) begin
      n = key_len_t'(MAX_KEY_BYTES);
    end
    return n;
  endfunction

endpackage

/* rtl/core/rc4_if.sv */
// ----------------------------------------------------------------------------
// RC4 channel interfaces
// Valid/ready channels for data/rekey words, results and register writes.
// ----------------------------------------------------------------------------

interface rc4_in_if;
  logic            valid;
  logic            ready;
  rc4_pkg::op_e    op;
  rc4_pkg::byte_t  data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

interface rc4_out_if;
  logic            valid;
  logic            ready;
  rc4_pkg::byte_t  keystream;
  rc4_pkg::byte_t  data_out;
  logic            rekey_done;

  modport source (output valid, output keystream, output data_out, output rekey_done,
                  input ready);
  modport sink   (input valid, input keystream, input data_out, input rekey_done,
                  output ready);
endinterface

interface rc4_cfg_if;
  logic                valid;
  logic                ready;
  rc4_pkg::cfg_idx_t   index;
  rc4_pkg::key_reg_t   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/rc4_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Same-address read and write return the old contents.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/rc4_keystream_cipher_top.sv */
// ----------------------------------------------------------------------------
// RC4 keystream cipher top level
// RC4 key schedule and keystream generator around one 256 x 8 table RAM.
// ----------------------------------------------------------------------------
// The block takes one word at a time on in_i. A data word (op = OP_DATA)
// goes through these steps from acceptance to its result being loaded into
// the output register: read S[i+1], read S[j], write S[i] while reading
// S[S[i]+S[j]], write S[j]. The steps are set by the single read and single
// write port of the permutation RAM. A rekey word (op = OP_REKEY) rewrites
// the table to the identity and then runs the key schedule on each entry
// (read S[n], read S[acc], write S[n], write S[acc]); both generator indices
// are cleared when it finishes and it answers with rekey_done = 1 and zero
// bytes. After reset the block loads the identity permutation and accepts
// no word until then; register writes on cfg_i are taken at any time but
// must only be issued while no word is in flight.
// The result sits in an output register, so the next word is accepted while
// a result still waits on out_o.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_keystream_cipher_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  rc4_in_if.sink        in_i,
  rc4_out_if.source     out_o,
  rc4_cfg_if.sink       cfg_i
);

  // Sequencer codes
  localparam logic [3:0] ST_INIT    = 4'd0;  // identity fill sweep
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_KS_RD_N = 4'd2;  // schedule: read S[n]
  localparam logic [3:0] ST_KS_RD_A = 4'd3;  // schedule: update acc, read S[acc]
  localparam logic [3:0] ST_KS_WR_N = 4'd4;  // schedule: S[n] <= S[acc]
  localparam logic [3:0] ST_KS_WR_A = 4'd5;  // schedule: S[acc] <= old S[n]
  localparam logic [3:0] ST_D_RD_I  = 4'd6;  // data: read S[i+1]
  localparam logic [3:0] ST_D_RD_J  = 4'd7;  // data: update j, read S[j]
  localparam logic [3:0] ST_D_WR_I  = 4'd8;  // data: S[i] <= S[j], read S[t]
  localparam logic [3:0] ST_D_WR_J  = 4'd9;  // data: S[j] <= S[i], emit

  logic [3:0]        state_q, state_d;
  rc4_pkg::byte_t    cnt_q, cnt_d;       // table entry for fill and schedule
  rc4_pkg::byte_t    acc_q, acc_d;       // schedule accumulator
  rc4_pkg::key_pos_t pos_q, pos_d;       // key byte position
  logic              rekey_q, rekey_d;   // fill sweep belongs to a rekey
  rc4_pkg::byte_t    i_q, i_d;
  rc4_pkg::byte_t    j_q, j_d;

  // Operand holding registers
  rc4_pkg::byte_t    si_q, si_d;
  rc4_pkg::byte_t    sj_q, sj_d;
  rc4_pkg::byte_t    t_q, t_d;
  rc4_pkg::byte_t    din_q, din_d;

  // Configuration
  rc4_pkg::key_len_t key_len_q;
  rc4_pkg::key_reg_t key_low_q;
  rc4_pkg::key_reg_t key_high_q;

  // Output register
  logic              out_valid_q;
  rc4_pkg::byte_t    out_ks_q;
  rc4_pkg::byte_t    out_dout_q;
  logic              out_rekey_q;
  logic              out_free;
  logic              out_load;
  logic              out_load_rekey;

  // RAM port
  logic              ram_we;
  rc4_pkg::byte_t    ram_waddr;
  rc4_pkg::byte_t    ram_wdata;
  logic              ram_re;
  rc4_pkg::byte_t    ram_raddr;
  rc4_pkg::byte_t    ram_rdata;

  // Datapath helpers
  rc4_pkg::key_len_t eff_len;
  rc4_pkg::key_len_t pos_inc;
  logic [2*rc4_pkg::KEY_REG_W-1:0] key_w;
  rc4_pkg::byte_t    key_byte;
  rc4_pkg::byte_t    acc_sum;
  rc4_pkg::byte_t    ks_w;
  logic              in_fire;

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign eff_len  = rc4_pkg::eff_key_len(key_len_q);
  assign pos_inc  = rc4_pkg::key_len_t'(pos_q) + rc4_pkg::key_len_t'(1);
  assign key_w    = {key_high_q, key_low_q};
  assign key_byte = key_w[{pos_q, 3'b000} +: rc4_pkg::BYTE_W];
  assign acc_sum  = rc4_pkg::byte_t'(acc_q + ram_rdata + key_byte);

  // S[t] was read in the cycle that wrote S[i], and S[j] is written now:
  // forward both so the keystream byte sees the swapped table.
  always_comb begin
    priority if (t_q == i_q) begin
      ks_w = sj_q;
    end else if (t_q == j_q) begin
      ks_w = si_q;
    end else begin
      ks_w = ram_rdata;
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    acc_d          = acc_q;
    pos_d          = pos_q;
    rekey_d        = rekey_q;
    i_d            = i_q;
    j_d            = j_q;
    si_d           = si_q;
    sj_d           = sj_q;
    t_d            = t_q;
    din_d          = din_q;
    ram_we         = 1'b0;
    ram_waddr      = cnt_q;
    ram_wdata      = cnt_q;
    ram_re         = 1'b0;
    ram_raddr      = cnt_q;
    out_load       = 1'b0;
    out_load_rekey = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
        cnt_d  = rc4_pkg::byte_t'(cnt_q + 8'd1);
        if (&cnt_q) begin
          acc_d   = '0;
          pos_d   = '0;
          state_d = rekey_q ? ST_KS_RD_N : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.op == rc4_pkg::OP_REKEY) begin
            rekey_d = 1'b1;
            cnt_d   = '0;
            state_d = ST_INIT;
          end else begin
            din_d   = in_i.data_in;
            state_d = ST_D_RD_I;
          end
        end
      end
      ST_KS_RD_N: begin
        ram_re  = 1'b1;
        state_d = ST_KS_RD_A;
      end
      ST_KS_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = acc_sum;
        acc_d     = acc_sum;
        si_d      = ram_rdata;
        state_d   = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        state_d   = ST_KS_WR_A;
      end
      ST_KS_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = acc_q;
        ram_wdata = si_q;
        if (&cnt_q) begin
          // Hold on the final write until the output register frees up.
          if (out_free) begin
            out_load       = 1'b1;
            out_load_rekey = 1'b1;
            i_d            = '0;
            j_d            = '0;
            rekey_d        = 1'b0;
            state_d        = ST_IDLE;
          end
        end else begin
          cnt_d   = rc4_pkg::byte_t'(cnt_q + 8'd1);
          pos_d   = (pos_inc >= eff_len) ? '0 : pos_inc[rc4_pkg::KEY_POS_W-1:0];
          state_d = ST_KS_RD_N;
        end
      end
      ST_D_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = rc4_pkg::byte_t'(i_q + 8'd1);
        i_d       = rc4_pkg::byte_t'(i_q + 8'd1);
        state_d   = ST_D_RD_J;
      end
      ST_D_RD_J: begin
        ram_re    = 1'b1;
        ram_raddr = rc4_pkg::byte_t'(j_q + ram_rdata);
        j_d       = rc4_pkg::byte_t'(j_q + ram_rdata);
        si_d      = ram_rdata;
        state_d   = ST_D_WR_I;
      end
      ST_D_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = rc4_pkg::byte_t'(si_q + ram_rdata);
        sj_d      = ram_rdata;
        t_d       = rc4_pkg::byte_t'(si_q + ram_rdata);
        state_d   = ST_D_WR_J;
      end
      ST_D_WR_J: begin
        // Rewriting S[j] while stalled is harmless; read data holds.
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
      acc_q   <= '0;
      pos_q   <= '0;
      rekey_q <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      rekey_q <= rekey_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  // Operand holding registers
  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    t_q   <= t_d;
    din_q <= din_d;
  end

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q  <= rc4_pkg::key_len_t'(1);
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rc4_pkg::REG_KEY_LENGTH: key_len_q  <= cfg_i.wdata[rc4_pkg::KEY_LEN_W-1:0];
        rc4_pkg::REG_KEY_LOW:    key_low_q  <= cfg_i.wdata;
        rc4_pkg::REG_KEY_HIGH:   key_high_q <= cfg_i.wdata;
        default: begin
        end
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ks_q    <= out_load_rekey ? '0 : ks_w;
      out_dout_q  <= out_load_rekey ? '0 : rc4_pkg::byte_t'(din_q ^ ks_w);
      out_rekey_q <= out_load_rekey;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.keystream  = out_ks_q;
  assign out_o.data_out   = out_dout_q;
  assign out_o.rekey_done = out_rekey_q;

  // A same-entry read and write may only meet where the keystream
  // forwarding covers it.
  `ASSERT_RST(a_ram_hazard, clk_i, rst_ni,
              (ram_we && ram_re && (ram_waddr == ram_raddr)) |-> (state_q == ST_D_WR_I),
              "unforwarded RAM read/write collision")
  `ASSERT_RST(a_accept_leaves_idle, clk_i, rst_ni,
              in_fire |=> (state_q != ST_IDLE),
              "accepted word did not start work")
  `ASSERT_RST(a_rekey_clears_idx, clk_i, rst_ni,
              (out_load && out_load_rekey) |=>
                (out_valid_q && out_rekey_q && (i_q == '0) && (j_q == '0)),
              "rekey result without cleared indices")
  `ASSERT_RST(a_key_pos_range, clk_i, rst_ni,
              (state_q == ST_KS_RD_A) |-> (rc4_pkg::key_len_t'(pos_q) < eff_len),
              "key position beyond key length")
  `ASSERT_ALWAYS(a_no_load_when_full, clk_i,
                 (rst_ni && out_load && out_valid_q) |-> out_o.ready,
                 "result loaded over a pending result")

endmodule
